[rtl/core/huffman_code_builder_macros.svh]
// assertion macros for the huffman code builder
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH
`ifndef ASSERT_OFF
`define HCB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define HCB_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define HCB_ASSERT(label, clk, rst_n, prop)
`define HCB_ASSERT_RST(label, clk, prop)
`endif
`endif

[rtl/core/hcb_pkg.sv]
// shared types and constants of the huffman code builder
package hcb_pkg;
  localparam int unsigned SymW  = 8;
  localparam int unsigned FreqW = 16;
  localparam int unsigned CodeW = 15;
  localparam int unsigned LenW  = 4;
  localparam int unsigned StatW = 2;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatEmpty    = 2'd1;
  localparam logic [StatW-1:0] StatOverflow = 2'd2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdBuild = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StSiftRd,
    StSiftCmp,
    StPopTop,
    StPushRd,
    StPushCmp,
    StWalkRd,
    StWalkDec,
    StEmpty
  } state_e;

  // sift mode: what follows a finished sift
  typedef enum logic [1:0] {
    SmHeapify,
    SmPopA,
    SmPopB
  } sift_mode_e;

  typedef struct packed {
    logic start_build;
    logic init_step;
    logic sift_rd;
    logic sift_cmp;
    logic pop_top;
    sift_mode_e mode;
    logic push_rd;
    logic push_cmp;
    logic walk_rd;
    logic walk_dec;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic init_done;
    logic sift_done;
    logic heapify_done;
    logic heap_single;
    logic heap_empty;
    logic push_done;
    logic walk_done;
  } stat_t;
endpackage

[rtl/core/huffman_code_builder.sv]
// huffman code builder top level
//   channel  signals                                     direction
//   command  start_i busy_o command_i symbol_i frequency_i  in
//   result   strobe_o out_symbol_o code_bits_o ...         out
// a load stores one symbol; a build seeds the heap with one entry per symbol
// each heap sift or push level has a read state and a compare state; a pop has its own state
// the tree walk reads and decodes each node in turn and emits one result per leaf
// an empty build passes through the empty state, which registers its status result
// reset clears the store count, overflow flag and sequencer
// results cannot be stalled; busy_o holds off commands during a build
`include "huffman_code_builder_macros.svh"
module huffman_code_builder #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      command_i,
  input  logic [hcb_pkg::SymW-1:0]  symbol_i,
  input  logic [hcb_pkg::FreqW-1:0] frequency_i,
  output logic                      strobe_o,
  output logic [hcb_pkg::SymW-1:0]  out_symbol_o,
  output logic [hcb_pkg::CodeW-1:0] code_bits_o,
  output logic [hcb_pkg::LenW-1:0]  code_length_o,
  output logic [hcb_pkg::StatW-1:0] status_o,
  output logic                      last_o
);
  localparam int unsigned IdxW  = $clog2(MAX_SYMBOLS);
  localparam int unsigned CntW  = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned NodeW = $clog2(2 * MAX_SYMBOLS);

  hcb_pkg::cmd_t  cmd;
  hcb_pkg::stat_t stat;
  logic           accept;

  assign accept = start_i && !busy_o;

  hcb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .build_i (accept && command_i == hcb_pkg::CmdBuild),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  hcb_datapath #(
    .MaxSym (MAX_SYMBOLS),
    .IdxW   (IdxW),
    .CntW   (CntW),
    .NodeW  (NodeW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && command_i == hcb_pkg::CmdLoad),
    .symbol_i      (symbol_i),
    .frequency_i   (frequency_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .strobe_o      (strobe_o),
    .out_symbol_o  (out_symbol_o),
    .code_bits_o   (code_bits_o),
    .code_length_o (code_length_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  `HCB_ASSERT(a_last_strobe, clk_i, rst_ni, last_o && strobe_o |=> !strobe_o)
  `HCB_ASSERT(a_build_busy, clk_i, rst_ni, accept && command_i |=> busy_o)
  `HCB_ASSERT_RST(a_reset_idle, clk_i, !rst_ni |=> !busy_o)
endmodule

[rtl/core/hcb_datapath.sv]
// storage, heap and tree walk datapath of the huffman code builder
module hcb_datapath #(
  parameter int unsigned MaxSym = 16,
  parameter int unsigned IdxW   = 4,
  parameter int unsigned CntW   = 5,
  parameter int unsigned NodeW  = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [hcb_pkg::SymW-1:0]  symbol_i,
  input  logic [hcb_pkg::FreqW-1:0] frequency_i,
  input  hcb_pkg::cmd_t             cmd_i,
  output hcb_pkg::stat_t            stat_o,
  output logic                      strobe_o,
  output logic [hcb_pkg::SymW-1:0]  out_symbol_o,
  output logic [hcb_pkg::CodeW-1:0] code_bits_o,
  output logic [hcb_pkg::LenW-1:0]  code_length_o,
  output logic [hcb_pkg::StatW-1:0] status_o,
  output logic                      last_o
);
  localparam int unsigned NodeCap = 2 * MaxSym;
  localparam int unsigned WtW     = hcb_pkg::FreqW + NodeW;
  localparam int unsigned SpW     = NodeW + 1;
  localparam int unsigned DepW    = NodeW;

  logic [hcb_pkg::SymW-1:0] leaf_mem [MaxSym];
  logic [WtW-1:0]           wt_mem   [NodeCap];
  logic [NodeW-1:0]         left_mem [NodeCap];
  logic [NodeW-1:0]         right_mem[NodeCap];
  logic [NodeW-1:0]         heap_q   [MaxSym];
  logic [NodeW-1:0]         stk_node [NodeCap];
  logic [DepW-1:0]          stk_dep  [NodeCap];
  logic [hcb_pkg::CodeW-1:0] stk_code[NodeCap];

  logic [CntW-1:0] count_q, n_q, hsize_q;
  logic            ovf_q;
  logic [hcb_pkg::StatW-1:0] stat_q;
  logic [CntW-1:0] pos_q, heapi_q, push_i_q, hfy_q;
  logic [NodeW-1:0] next_q, a_q;
  logic [WtW-1:0]  wp_q, wl_q, wr_q, wnew_q;
  logic [NodeW-1:0] hl_q, hr_q, hp_q, hpar_q;
  logic [SpW-1:0]  sp_q;
  logic [NodeW-1:0] wnode_q;
  logic [DepW-1:0]  wdep_q;
  logic [hcb_pkg::CodeW-1:0] wcode_q;
  logic [hcb_pkg::SymW-1:0] wsym_q;
  logic [CntW-1:0] produced_q;

  logic [CntW:0] lpos, rpos;
  logic [CntW-1:0] parent;
  logic [CntW-1:0] best_c;
  logic [WtW-1:0]  wbest;

  assign lpos   = {pos_q, 1'b1};
  assign rpos   = {pos_q, 1'b0} + (CntW+1)'(2);
  assign parent = (push_i_q - CntW'(1)) >> 1;

  always_comb begin
    best_c = pos_q;
    wbest  = wp_q;
    if (lpos < {1'b0, hsize_q} && wl_q < wbest) begin
      best_c = lpos[CntW-1:0];
      wbest  = wl_q;
    end
    if (rpos < {1'b0, hsize_q} && wr_q < wbest) begin
      best_c = rpos[CntW-1:0];
    end
  end

  assign stat_o.n_zero       = (count_q == '0);
  assign stat_o.init_done    = (heapi_q == n_q - CntW'(1));
  assign stat_o.sift_done    = (best_c == pos_q);
  assign stat_o.heapify_done = (hfy_q == '0);
  assign stat_o.heap_single  = (hsize_q <= CntW'(1));
  assign stat_o.heap_empty   = (hsize_q == '0);
  assign stat_o.push_done    = (push_i_q == '0) || !(wnew_q < wp_q);
  assign stat_o.walk_done    = (sp_q == '0) && (wnode_q < NodeW'(n_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      if (load_i) begin
        if (count_q < CntW'(MaxSym)) begin
          count_q <= count_q + CntW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.start_build) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.emit_empty) begin
        strobe_o <= 1'b1;
      end
      if (cmd_i.walk_dec && wnode_q < NodeW'(n_q)) begin
        strobe_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && count_q < CntW'(MaxSym)) begin
      leaf_mem[count_q[IdxW-1:0]] <= symbol_i;
      wt_mem[NodeW'(count_q)]     <= WtW'(frequency_i);
    end
    if (cmd_i.start_build) begin
      n_q     <= count_q;
      hsize_q <= count_q;
      stat_q  <= ovf_q ? hcb_pkg::StatOverflow : hcb_pkg::StatOk;
      heapi_q <= '0;
      next_q  <= NodeW'(count_q);
      produced_q <= '0;
      pos_q   <= (count_q > CntW'(1)) ? (count_q >> 1) - CntW'(1) : '0;
      hfy_q   <= (count_q > CntW'(1)) ? (count_q >> 1) - CntW'(1) : '0;
    end
    if (cmd_i.init_step) begin
      heap_q[heapi_q[IdxW-1:0]] <= NodeW'(heapi_q);
      heapi_q <= heapi_q + CntW'(1);
    end
    if (cmd_i.sift_rd) begin
      hp_q <= heap_q[pos_q[IdxW-1:0]];
      hl_q <= heap_q[lpos[IdxW-1:0]];
      hr_q <= heap_q[rpos[IdxW-1:0]];
      wp_q <= wt_mem[heap_q[pos_q[IdxW-1:0]]];
      wl_q <= wt_mem[heap_q[lpos[IdxW-1:0]]];
      wr_q <= wt_mem[heap_q[rpos[IdxW-1:0]]];
    end
    if (cmd_i.sift_cmp) begin
      if (best_c != pos_q) begin
        heap_q[pos_q[IdxW-1:0]]  <= (best_c == lpos[CntW-1:0]) ? hl_q : hr_q;
        heap_q[best_c[IdxW-1:0]] <= hp_q;
        pos_q <= best_c;
      end else if (cmd_i.mode == hcb_pkg::SmHeapify) begin
        pos_q <= hfy_q - CntW'(1);
        hfy_q <= hfy_q - CntW'(1);
      end
    end
    if (cmd_i.pop_top) begin
      if (cmd_i.mode == hcb_pkg::SmPopA) begin
        a_q <= heap_q[0];
      end else begin
        left_mem[next_q]  <= a_q;
        right_mem[next_q] <= heap_q[0];
        wnew_q <= wt_mem[a_q] + wt_mem[heap_q[0]];
      end
      heap_q[0] <= heap_q[IdxW'(hsize_q - CntW'(1))];
      hsize_q   <= hsize_q - CntW'(1);
      pos_q     <= '0;
    end
    if (cmd_i.push_rd) begin
      if (push_i_q != '0) begin
        hpar_q <= heap_q[parent[IdxW-1:0]];
        wp_q   <= wt_mem[heap_q[parent[IdxW-1:0]]];
      end
    end
    if (cmd_i.push_cmp) begin
      if (push_i_q != '0 && wnew_q < wp_q) begin
        heap_q[push_i_q[IdxW-1:0]] <= hpar_q;
        push_i_q <= parent;
      end else begin
        heap_q[push_i_q[IdxW-1:0]] <= next_q;
        wt_mem[next_q] <= wnew_q;
        next_q <= next_q + NodeW'(1);
        hsize_q <= hsize_q + CntW'(1);
        if (hsize_q + CntW'(1) <= CntW'(1)) begin
          stk_node[0] <= next_q;
          stk_dep[0]  <= '0;
          stk_code[0] <= '0;
          sp_q <= SpW'(1);
        end
      end
    end
    if (cmd_i.sift_cmp && best_c == pos_q && cmd_i.mode == hcb_pkg::SmPopB) begin
      push_i_q <= hsize_q;
    end
    if (cmd_i.sift_cmp && best_c == pos_q && cmd_i.mode == hcb_pkg::SmHeapify
        && hfy_q == '0 && hsize_q <= CntW'(1)) begin
      stk_node[0] <= heap_q[0];
      stk_dep[0]  <= '0;
      stk_code[0] <= '0;
      sp_q <= SpW'(1);
    end
    if (cmd_i.walk_rd) begin
      wnode_q <= stk_node[sp_q[NodeW-1:0] - NodeW'(1)];
      wdep_q  <= stk_dep[sp_q[NodeW-1:0] - NodeW'(1)];
      wcode_q <= stk_code[sp_q[NodeW-1:0] - NodeW'(1)];
      wsym_q  <= leaf_mem[IdxW'(stk_node[sp_q[NodeW-1:0] - NodeW'(1)])];
      sp_q    <= sp_q - SpW'(1);
    end
    if (cmd_i.walk_dec) begin
      if (wnode_q < NodeW'(n_q)) begin
        out_symbol_o  <= wsym_q;
        code_bits_o   <= wcode_q;
        code_length_o <= wdep_q[hcb_pkg::LenW-1:0];
        status_o      <= stat_q;
        last_o        <= (produced_q == n_q - CntW'(1));
        produced_q    <= produced_q + CntW'(1);
      end else begin
        stk_node[sp_q[NodeW-1:0]]              <= right_mem[wnode_q];
        stk_dep[sp_q[NodeW-1:0]]               <= wdep_q + DepW'(1);
        stk_code[sp_q[NodeW-1:0]]              <= {wcode_q[hcb_pkg::CodeW-2:0], 1'b1};
        stk_node[sp_q[NodeW-1:0] + NodeW'(1)]  <= left_mem[wnode_q];
        stk_dep[sp_q[NodeW-1:0] + NodeW'(1)]   <= wdep_q + DepW'(1);
        stk_code[sp_q[NodeW-1:0] + NodeW'(1)]  <= {wcode_q[hcb_pkg::CodeW-2:0], 1'b0};
        sp_q <= sp_q + SpW'(2);
      end
    end
    if (cmd_i.emit_empty) begin
      out_symbol_o  <= '0;
      code_bits_o   <= '0;
      code_length_o <= '0;
      status_o      <= hcb_pkg::StatEmpty;
      last_o        <= 1'b1;
    end
  end
endmodule

[rtl/core/hcb_ctrl.sv]
// build sequencer of the huffman code builder
module hcb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           build_i,
  input  hcb_pkg::stat_t stat_i,
  output hcb_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  hcb_pkg::state_e     state_q, state_d;
  hcb_pkg::sift_mode_e mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcb_pkg::StIdle;
      mode_q  <= hcb_pkg::SmHeapify;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      hcb_pkg::StIdle: begin
        if (build_i) begin
          state_d = stat_i.n_zero ? hcb_pkg::StEmpty : hcb_pkg::StInit;
          mode_d  = hcb_pkg::SmHeapify;
        end
      end
      hcb_pkg::StInit: begin
        if (stat_i.init_done) begin
          state_d = stat_i.heap_single ? hcb_pkg::StSiftCmp : hcb_pkg::StSiftRd;
        end
      end
      hcb_pkg::StSiftRd: state_d = hcb_pkg::StSiftCmp;
      hcb_pkg::StSiftCmp: begin
        if (!stat_i.sift_done) begin
          state_d = hcb_pkg::StSiftRd;
        end else begin
          case (mode_q)
            hcb_pkg::SmHeapify: begin
              if (!stat_i.heapify_done) begin
                state_d = hcb_pkg::StSiftRd;
              end else if (stat_i.heap_single) begin
                state_d = hcb_pkg::StWalkRd;
              end else begin
                state_d = hcb_pkg::StPopTop;
                mode_d  = hcb_pkg::SmPopA;
              end
            end
            hcb_pkg::SmPopA: begin
              state_d = hcb_pkg::StPopTop;
              mode_d  = hcb_pkg::SmPopB;
            end
            default: state_d = hcb_pkg::StPushRd;
          endcase
        end
      end
      hcb_pkg::StPopTop: state_d = hcb_pkg::StSiftRd;
      hcb_pkg::StPushRd: state_d = hcb_pkg::StPushCmp;
      hcb_pkg::StPushCmp: begin
        if (!stat_i.push_done) begin
          state_d = hcb_pkg::StPushRd;
        end else if (stat_i.heap_empty) begin
          state_d = hcb_pkg::StWalkRd;
        end else begin
          state_d = hcb_pkg::StPopTop;
          mode_d  = hcb_pkg::SmPopA;
        end
      end
      hcb_pkg::StWalkRd: state_d = hcb_pkg::StWalkDec;
      hcb_pkg::StWalkDec: state_d = stat_i.walk_done ? hcb_pkg::StIdle : hcb_pkg::StWalkRd;
      hcb_pkg::StEmpty: state_d = hcb_pkg::StIdle;
      default: state_d = hcb_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.mode        = mode_q;
    cmd_o.start_build = (state_q == hcb_pkg::StIdle) && build_i;
    cmd_o.init_step   = (state_q == hcb_pkg::StInit);
    cmd_o.sift_rd     = (state_q == hcb_pkg::StSiftRd);
    cmd_o.sift_cmp    = (state_q == hcb_pkg::StSiftCmp);
    cmd_o.pop_top     = (state_q == hcb_pkg::StPopTop);
    cmd_o.push_rd     = (state_q == hcb_pkg::StPushRd);
    cmd_o.push_cmp    = (state_q == hcb_pkg::StPushCmp);
    cmd_o.walk_rd     = (state_q == hcb_pkg::StWalkRd);
    cmd_o.walk_dec    = (state_q == hcb_pkg::StWalkDec);
    cmd_o.emit_empty  = (state_q == hcb_pkg::StEmpty);
    busy_o            = (state_q != hcb_pkg::StIdle);
  end
endmodule
